// ----- rtl/dis_pkg.sv -----
// Shared types, constants and round functions for the differential image size sampler.
package dis_pkg;

    typedef logic [7:0][31:0] t_ws;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R57,
        ST_C58,
        ST_R58,
        ST_C59,
        ST_R59,
        ST_C60,
        ST_SAMP,
        ST_DRAIN,
        ST_KEY,
        ST_KWAIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_OUT
    } t_state;

    localparam logic [31:0] K57 = 32'h78a5636f;
    localparam logic [31:0] K58 = 32'h84c87814;
    localparam logic [31:0] K59 = 32'h8cc70208;
    localparam logic [31:0] K60 = 32'h90befffa;

    localparam int CFG_IDX_W = 4;
    localparam int NUM_PAIR  = 8;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(logic [31:0] a);
        return rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] big_s1(logic [31:0] e);
        return rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [31:0] small_s1(logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch(logic [31:0] e, logic [31:0] f, logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic t_ws sha_round(t_ws p, logic [31:0] w, logic [31:0] k);
        t_ws         r;
        logic [31:0] t1;
        logic [31:0] t2;
        t1   = p[7] + big_s1(p[4]) + ch(p[4], p[5], p[6]) + k + w;
        t2   = big_s0(p[0]) + maj(p[0], p[1], p[2]);
        r[0] = t1 + t2;
        r[1] = p[0];
        r[2] = p[1];
        r[3] = p[2];
        r[4] = p[3] + t1;
        r[5] = p[4];
        r[6] = p[5];
        r[7] = p[6];
        return r;
    endfunction

    function automatic logic [31:0] cascade(t_ws x, t_ws y);
        logic [31:0] d;
        d = x[7] - y[7];
        d = d + (big_s1(x[4]) - big_s1(y[4]));
        d = d + (ch(x[4], x[5], x[6]) - ch(y[4], y[5], y[6]));
        d = d + (big_s0(x[0]) + maj(x[0], x[1], x[2]));
        d = d - (big_s0(y[0]) + maj(y[0], y[1], y[2]));
        return d;
    endfunction

    function automatic logic [63:0] xorshift(logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

endpackage

// ----- rtl/dis_if.sv -----
// Request channel interfaces for the sampler input, result and register write port.
interface dis_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word57;
    logic [31:0] word58;
    logic [31:0] word59;
    logic [31:0] first_word_diff;
    logic [31:0] sched_diff;
    logic [63:0] rng_seed;
    logic [10:0] sample_count;
    modport source (output valid, word57, word58, word59, first_word_diff, sched_diff,
                    rng_seed, sample_count, input ready);
    modport sink   (input valid, word57, word58, word59, first_word_diff, sched_diff,
                    rng_seed, sample_count, output ready);
endinterface

interface dis_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] distinct_count;
    logic        target_hit;
    modport source (output valid, distinct_count, target_hit, input ready);
    modport sink   (input valid, distinct_count, target_hit, output ready);
endinterface

interface dis_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dis_pkg::CFG_IDX_W-1:0]   idx;
    logic [63:0]                     data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// ----- rtl/differential_image_size_sampler.sv -----
// Top level of the differential image size sampler.
// Usage:
//   i_cfg writes the eight round-57 state word pairs (index 0..7 = a..h, upper half
//   first message, lower half second message); always ready, write only when idle.
//   i_in takes one request: three schedule words, the round-57 word difference, the
//   schedule difference, a 64-bit xorshift seed and a sample count (0 acts as 1,
//   values above MAX_SAMPLES saturate). o_out returns one result per request.
// Sequence for n samples: setup steps (rounds 57..59 and cascade differences,
//   one sequencer step each), then the three-stage round-60 pipeline
//   that writes one sample per cycle into the sample RAM, then the duplicate scan:
//   for each sample i >= 1, one RAM read per cycle of samples 0..i-1 against sample i.
//   The scan reads through the single read port of the sample RAM.
// Throughput: one request at a time; a new request is taken while the last result
//   still waits on o_out, and the block holds the new result until it is taken.
// Reset clears all pair words to zero and returns the block to idle with no result
//   pending. The sample RAM is not cleared; only entries of the current request are read.
module differential_image_size_sampler #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dis_in_if.sink    i_in,
    dis_out_if.source o_out,
    dis_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    dis_pkg::t_state r_state;
    dis_pkg::t_state n_state;

    logic [63:0]       r_pw [dis_pkg::NUM_PAIR];
    logic [31:0]       r_w58;
    logic [31:0]       r_w59;
    logic [31:0]       r_sd;
    logic [63:0]       r_rng;
    logic [CW-1:0]     r_n;
    dis_pkg::t_ws      r_s1;
    dis_pkg::t_ws      r_s2;
    logic [31:0]       r_c;
    logic [31:0]       r_target;
    logic [CW-1:0]     r_iss;
    logic              r_v1;
    logic [31:0]       r_w60;
    logic              r_v2;
    dis_pkg::t_ws      r_b1;
    dis_pkg::t_ws      r_b2;
    logic              r_v3;
    logic [31:0]       r_val;
    logic [CW-1:0]     r_widx;
    logic              r_hit;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    logic [31:0]       r_key;
    logic              r_pend;
    logic              r_dup;
    logic [CW-1:0]     r_dist;
    logic              r_ovalid;
    logic [10:0]       r_odist;
    logic              r_ohit;

    logic [AW-1:0]     raddr;
    logic [31:0]       rdata;
    logic              dup_now;
    logic              in_acc;
    logic [CW-1:0]     cnt_sel;
    logic [63:0]       rng_next;
    dis_pkg::t_ws      pw_hi;
    dis_pkg::t_ws      pw_lo;

    dis_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (r_v3),
        .i_waddr (r_widx[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        for (int k = 0; k < dis_pkg::NUM_PAIR; k++) begin
            pw_hi[k] = r_pw[k][63:32];
            pw_lo[k] = r_pw[k][31:0];
        end
    end

    always_comb begin
        if (i_in.sample_count == 11'd0) begin
            cnt_sel = CW'(1);
        end else if (32'(i_in.sample_count) > 32'(MAX_SAMPLES)) begin
            cnt_sel = CW'(MAX_SAMPLES);
        end else begin
            cnt_sel = CW'(i_in.sample_count);
        end
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign rng_next = dis_pkg::xorshift(r_rng);
    assign dup_now  = r_dup || (r_pend && (rdata == r_key));

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == dis_pkg::ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.distinct_count = r_odist;
    assign o_out.target_hit     = r_ohit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dis_pkg::ST_IDLE:     if (in_acc) n_state = dis_pkg::ST_R57;
            dis_pkg::ST_R57:      n_state = dis_pkg::ST_C58;
            dis_pkg::ST_C58:      n_state = dis_pkg::ST_R58;
            dis_pkg::ST_R58:      n_state = dis_pkg::ST_C59;
            dis_pkg::ST_C59:      n_state = dis_pkg::ST_R59;
            dis_pkg::ST_R59:      n_state = dis_pkg::ST_C60;
            dis_pkg::ST_C60:      n_state = dis_pkg::ST_SAMP;
            dis_pkg::ST_SAMP:     if (r_iss == r_n - CW'(1)) n_state = dis_pkg::ST_DRAIN;
            dis_pkg::ST_DRAIN: begin
                if (r_widx == r_n) begin
                    n_state = (r_n == CW'(1)) ? dis_pkg::ST_OUT : dis_pkg::ST_KEY;
                end
            end
            dis_pkg::ST_KEY:      n_state = dis_pkg::ST_KWAIT;
            dis_pkg::ST_KWAIT:    n_state = dis_pkg::ST_SCAN;
            dis_pkg::ST_SCAN:     if (r_j == r_i - CW'(1)) n_state = dis_pkg::ST_SCAN_END;
            dis_pkg::ST_SCAN_END: begin
                n_state = (r_i == r_n - CW'(1)) ? dis_pkg::ST_OUT : dis_pkg::ST_KEY;
            end
            dis_pkg::ST_OUT:      if (!r_ovalid || o_out.ready) n_state = dis_pkg::ST_IDLE;
            default:              n_state = dis_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            dis_pkg::ST_KEY:  raddr = r_i[AW-1:0];
            dis_pkg::ST_SCAN: raddr = r_j[AW-1:0];
            default:          raddr = r_i[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dis_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            for (int k = 0; k < dis_pkg::NUM_PAIR; k++) begin
                r_pw[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && 32'(i_cfg.idx) < dis_pkg::NUM_PAIR) begin
                r_pw[i_cfg.idx[2:0]] <= i_cfg.data;
            end
            r_v1 <= (r_state == dis_pkg::ST_SAMP);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            priority if (r_state == dis_pkg::ST_OUT && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w60 <= rng_next[31:0];
        r_b1  <= dis_pkg::sha_round(r_s1, r_w60, dis_pkg::K60);
        r_b2  <= dis_pkg::sha_round(r_s2, r_w60 + r_c, dis_pkg::K60);
        r_val <= dis_pkg::cascade(r_b1, r_b2);
        if (r_v3) begin
            r_widx <= r_widx + CW'(1);
            if (r_val == r_target) begin
                r_hit <= 1'b1;
            end
        end
        unique case (r_state)
            dis_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_s1   <= dis_pkg::sha_round(pw_hi, i_in.word57, dis_pkg::K57);
                    r_s2   <= dis_pkg::sha_round(pw_lo, i_in.word57 + i_in.first_word_diff,
                                                 dis_pkg::K57);
                    r_w58  <= i_in.word58;
                    r_w59  <= i_in.word59;
                    r_sd   <= i_in.sched_diff;
                    r_rng  <= i_in.rng_seed;
                    r_n    <= cnt_sel;
                    r_iss  <= '0;
                    r_widx <= '0;
                    r_hit  <= 1'b0;
                    r_dist <= CW'(1);
                    r_i    <= CW'(1);
                end
            end
            dis_pkg::ST_C58, dis_pkg::ST_C59, dis_pkg::ST_C60: begin
                r_c <= dis_pkg::cascade(r_s1, r_s2);
            end
            dis_pkg::ST_R58: begin
                r_s1 <= dis_pkg::sha_round(r_s1, r_w58, dis_pkg::K58);
                r_s2 <= dis_pkg::sha_round(r_s2, r_w58 + r_c, dis_pkg::K58);
            end
            dis_pkg::ST_R59: begin
                r_s1     <= dis_pkg::sha_round(r_s1, r_w59, dis_pkg::K59);
                r_s2     <= dis_pkg::sha_round(r_s2, r_w59 + r_c, dis_pkg::K59);
                r_target <= dis_pkg::small_s1(r_w59 + r_c) - dis_pkg::small_s1(r_w59) + r_sd;
            end
            dis_pkg::ST_SAMP: begin
                r_rng <= rng_next;
                r_iss <= r_iss + CW'(1);
            end
            dis_pkg::ST_KEY: begin
                r_pend <= 1'b0;
                r_dup  <= 1'b0;
            end
            dis_pkg::ST_KWAIT: begin
                r_key <= rdata;
                r_j   <= '0;
            end
            dis_pkg::ST_SCAN: begin
                r_dup  <= dup_now;
                r_pend <= 1'b1;
                r_j    <= r_j + CW'(1);
            end
            dis_pkg::ST_SCAN_END: begin
                if (!dup_now) begin
                    r_dist <= r_dist + CW'(1);
                end
                r_i <= r_i + CW'(1);
            end
            dis_pkg::ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    r_odist <= 11'(r_dist);
                    r_ohit  <= r_hit;
                end
            end
            default: begin
            end
        endcase
    end

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_widx < r_n))
        else $error("sample write beyond sample count");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dis_pkg::ST_OUT) |-> (r_dist <= r_n))
        else $error("distinct count exceeds sample count");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dis_pkg::ST_SCAN) |-> (r_j < r_i && r_i < r_n))
        else $error("duplicate scan index out of order");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dis_pkg::ST_KEY) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("scan started with samples in flight");
endmodule

// ----- rtl/dis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
